@@ design/rcsp_pkg.sv @@
// Shared constants and types for the command stream parser.
package rcsp_pkg;

    localparam int PHASE_W = 4;

    localparam logic [PHASE_W-1:0] PH_WAIT_STAR   = 4'd0;
    localparam logic [PHASE_W-1:0] PH_COUNT_START = 4'd1;
    localparam logic [PHASE_W-1:0] PH_COUNT_DIGIT = 4'd2;
    localparam logic [PHASE_W-1:0] PH_WAIT_DOLLAR = 4'd3;
    localparam logic [PHASE_W-1:0] PH_LEN_START   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_LEN_DIGIT   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_DATA        = 4'd6;
    localparam logic [PHASE_W-1:0] PH_TRAIL_ONE   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_TRAIL_TWO   = 4'd8;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_STAR   = 3'd1;
    localparam logic [2:0] ERR_BAD_COUNT = 3'd2;
    localparam logic [2:0] ERR_NO_DOLLAR = 3'd3;
    localparam logic [2:0] ERR_BAD_LEN   = 3'd4;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam int NUM_W = 13;
    localparam logic [NUM_W-1:0] NUM_SAT = 13'd8191;

    localparam int CNT_W = 6;
    localparam int IDX_W = 5;

    localparam int                 CFG_IDX_W          = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARG_CAP      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARG_LEN_LIMIT = 1'd1;

    localparam logic [CNT_W-1:0] ARG_CAP_RESET   = 6'd32;
    localparam logic [NUM_W-1:0] LEN_LIMIT_RESET = 13'd512;

    typedef struct packed {
        logic [2:0]       error_code;
        logic [CNT_W-1:0] arg_count;
        logic             arg_end;
        logic [IDX_W-1:0] arg_index;
        logic [7:0]       data_byte;
    } rcsp_payload_t;

endpackage

@@ design/resp_command_stream_parser_top.sv @@
// Command stream parser: byte-wide array-of-bulk-strings framing to payload beats.
//
// The parser takes one byte per beat on the s_ channel and returns exactly one
// result beat per input beat on m_, one beat per clock while the sink is ready.
// A command is '*' count CR LF, then per argument '$' length CR LF, the data
// bytes and two trailing bytes that are skipped unchecked. Payload bytes leave
// with m_tuser high and their argument index; the second trailing byte raises
// arg_end, and m_tlast on the last argument. A malformed line reports an error
// code on the failing byte and the parser returns to waiting for '*'. All
// parsing for a byte is combinational between the parse state registers
// and the result register; the result register holds a beat while the sink
// stalls and a new byte is taken in the same cycle the held beat leaves.
// The user must write configuration (cfg_index 0: argument count cap, 1:
// arg_length_limit) only while no beat is in flight; the block does not enforce it.
module resp_command_stream_parser_top #(
    parameter int ARG_SLOTS    = 32,
    parameter int LENGTH_BOUND = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [12:0] cfg_wdata,
    // input stream: tdata[7:0] in_byte
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // result stream: tdata[7:0] data_byte, [12:8] arg_index, [13] arg_end,
    // [19:14] arg_count, [22:20] error_code, [23] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    // tuser[0] data_valid
    output logic        m_tuser,
    // tlast: command_end
    output logic        m_tlast
);
    import rcsp_pkg::*;

    // Limits one bit wider than their configuration registers.
    localparam logic [CNT_W:0] SLOT_LIM = (CNT_W+1)'(ARG_SLOTS);
    localparam logic [NUM_W:0] LEN_LIM  = (NUM_W+1)'(LENGTH_BOUND);

    // configuration registers
    logic [CNT_W-1:0] arg_cap_reg;
    logic [NUM_W-1:0] len_limit_reg;

    // parse state
    logic [PHASE_W-1:0] phase_reg,    phase_next;
    logic [NUM_W-1:0]   value_reg,    value_next;
    logic               frozen_reg,   frozen_next;
    logic               negative_reg, negative_next;
    logic               cr_seen_reg,  cr_seen_next;
    logic [CNT_W-1:0]   total_reg,    total_next;
    logic [CNT_W-1:0]   cur_arg_reg,  cur_arg_next;
    logic [NUM_W-1:0]   left_reg,     left_next;

    // result register
    logic               m_valid_reg;
    rcsp_payload_t      pay_reg, pay_next;
    logic               dv_reg,  dv_next;
    logic               cend_reg, cend_next;

    logic               accept;
    logic [7:0]         b;
    logic               is_digit;
    logic [NUM_W+3:0]   value_x10;
    logic [NUM_W-1:0]   value_acc;
    logic               line_end;
    logic               value_neg;
    logic [CNT_W:0]     count_lim;
    logic [NUM_W:0]     length_lim;
    logic               cnt_hold;
    logic               go_idle;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;

    // Number line arithmetic: accumulate a decimal digit, saturate.
    assign is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
    assign value_x10 = {4'd0, value_reg} * 17'd10 + {9'd0, b - CH_ZERO};
    assign value_acc = (value_x10 > {4'd0, NUM_SAT}) ? NUM_SAT : value_x10[NUM_W-1:0];
    assign line_end  = cr_seen_reg && (b == CH_LF);
    assign value_neg = negative_reg && (value_reg != '0);

    // Effective limits: smaller of register and build-time bound.
    assign count_lim  = ({1'b0, arg_cap_reg} < SLOT_LIM) ? {1'b0, arg_cap_reg} : SLOT_LIM;
    assign length_lim = ({1'b0, len_limit_reg} < LEN_LIM) ? {1'b0, len_limit_reg} : LEN_LIM;

    always_comb begin
        phase_next    = phase_reg;
        value_next    = value_reg;
        frozen_next   = frozen_reg;
        negative_next = negative_reg;
        cr_seen_next  = cr_seen_reg;
        total_next    = total_reg;
        cur_arg_next  = cur_arg_reg;
        left_next     = left_reg;
        go_idle       = 1'b0;
        dv_next       = 1'b0;
        cend_next     = 1'b0;
        pay_next      = '0;

        unique case (phase_reg)
            PH_WAIT_STAR: begin
                if (b == CH_STAR) begin
                    value_next    = '0;
                    frozen_next   = 1'b0;
                    negative_next = 1'b0;
                    cr_seen_next  = 1'b0;
                    phase_next    = PH_COUNT_START;
                end else begin
                    pay_next.error_code = ERR_NO_STAR;
                    go_idle = 1'b1;
                end
            end
            PH_COUNT_START, PH_COUNT_DIGIT: begin
                if (line_end) begin
                    if (value_neg || value_reg == '0 ||
                        {1'b0, value_reg} > {{(NUM_W-CNT_W){1'b0}}, count_lim}) begin
                        pay_next.error_code = ERR_BAD_COUNT;
                        go_idle = 1'b1;
                    end else begin
                        total_next   = value_reg[CNT_W-1:0];
                        cur_arg_next = '0;
                        phase_next   = PH_WAIT_DOLLAR;
                    end
                end else begin
                    cr_seen_next = (b == CH_CR);
                    if (phase_reg == PH_COUNT_START && b == CH_MINUS) begin
                        negative_next = 1'b1;
                    end else if (!frozen_reg && is_digit) begin
                        value_next = value_acc;
                    end else begin
                        frozen_next = 1'b1;
                    end
                    phase_next = PH_COUNT_DIGIT;
                end
            end
            PH_WAIT_DOLLAR: begin
                if (b == CH_DOLLAR) begin
                    value_next    = '0;
                    frozen_next   = 1'b0;
                    negative_next = 1'b0;
                    cr_seen_next  = 1'b0;
                    phase_next    = PH_LEN_START;
                end else begin
                    pay_next.error_code = ERR_NO_DOLLAR;
                    go_idle = 1'b1;
                end
            end
            PH_LEN_START, PH_LEN_DIGIT: begin
                if (line_end) begin
                    if (value_neg || {1'b0, value_reg} >= length_lim) begin
                        pay_next.error_code = ERR_BAD_LEN;
                        go_idle = 1'b1;
                    end else begin
                        left_next  = value_reg;
                        phase_next = (value_reg != '0) ? PH_DATA : PH_TRAIL_ONE;
                    end
                end else begin
                    cr_seen_next = (b == CH_CR);
                    if (phase_reg == PH_LEN_START && b == CH_MINUS) begin
                        negative_next = 1'b1;
                    end else if (!frozen_reg && is_digit) begin
                        value_next = value_acc;
                    end else begin
                        frozen_next = 1'b1;
                    end
                    phase_next = PH_LEN_DIGIT;
                end
            end
            PH_DATA: begin
                dv_next            = 1'b1;
                pay_next.data_byte = b;
                pay_next.arg_index = cur_arg_reg[IDX_W-1:0];
                left_next          = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
                if (left_reg <= 13'd1) begin
                    phase_next = PH_TRAIL_ONE;
                end
            end
            PH_TRAIL_ONE: begin
                phase_next = PH_TRAIL_TWO;
            end
            PH_TRAIL_TWO: begin
                pay_next.arg_end   = 1'b1;
                pay_next.arg_index = cur_arg_reg[IDX_W-1:0];
                if ({1'b0, cur_arg_reg} + 7'd1 >= {1'b0, total_reg}) begin
                    cend_next = 1'b1;
                    go_idle   = 1'b1;
                end else begin
                    cur_arg_next = cur_arg_reg + 1'b1;
                    phase_next   = PH_WAIT_DOLLAR;
                end
            end
            default: begin
                go_idle = 1'b1;
            end
        endcase

        if (go_idle) begin
            phase_next    = PH_WAIT_STAR;
            value_next    = '0;
            frozen_next   = 1'b0;
            negative_next = 1'b0;
            cr_seen_next  = 1'b0;
            total_next    = '0;
            cur_arg_next  = '0;
            left_next     = '0;
        end

        // Show the count once the count line is through, through command end.
        cnt_hold = (phase_next != PH_WAIT_STAR) && (phase_next != PH_COUNT_START) &&
                   (phase_next != PH_COUNT_DIGIT);
        if (cnt_hold) begin
            pay_next.arg_count = total_next;
        end else if (cend_next) begin
            pay_next.arg_count = total_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arg_cap_reg   <= ARG_CAP_RESET;
            len_limit_reg <= LEN_LIMIT_RESET;
            phase_reg     <= PH_WAIT_STAR;
            value_reg     <= '0;
            frozen_reg    <= 1'b0;
            negative_reg  <= 1'b0;
            cr_seen_reg   <= 1'b0;
            total_reg     <= '0;
            cur_arg_reg   <= '0;
            left_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_ARG_CAP:       arg_cap_reg   <= cfg_wdata[CNT_W-1:0];
                    CFG_ARG_LEN_LIMIT: len_limit_reg <= cfg_wdata;
                    default:           ;
                endcase
            end
            // advance the parse state on every accepted byte
            if (accept) begin
                phase_reg    <= phase_next;
                value_reg    <= value_next;
                frozen_reg   <= frozen_next;
                negative_reg <= negative_next;
                cr_seen_reg  <= cr_seen_next;
                total_reg    <= total_next;
                cur_arg_reg  <= cur_arg_next;
                left_reg     <= left_next;
                m_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    // result payload: load on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (accept) begin
            pay_reg  <= pay_next;
            dv_reg   <= dv_next;
            cend_reg <= cend_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, pay_reg};
    assign m_tuser  = dv_reg;
    assign m_tlast  = cend_reg;

endmodule

@@ sim/rcsp_tb_pkg.sv @@
// Scoreboard for the command stream parser: per-byte prediction and result beat checks.
package rcsp_tb_pkg;

    import rcsp_pkg::*;

    localparam int TB_ARG_SLOTS    = 32;
    localparam int TB_LENGTH_BOUND = 4096;

    typedef struct {
        logic             data_valid;
        logic [7:0]       data_byte;
        logic [IDX_W-1:0] arg_index;
        logic             arg_end;
        logic             command_end;
        logic [CNT_W-1:0] arg_count;
        logic [2:0]       error_code;
    } parse_beat_t;

    class command_parse_tracker;

        int unsigned        arg_cap;
        int unsigned        len_limit;
        logic [PHASE_W-1:0] phase;
        int unsigned        num_value;
        bit                 num_frozen;
        bit                 num_negative;
        bit                 cr_seen;
        int unsigned        arg_total;
        int unsigned        cur_arg;
        int unsigned        bytes_left;
        parse_beat_t        expected_beats[$];
        int unsigned        mismatches;

        function new();
            arg_cap    = ARG_CAP_RESET;
            len_limit  = LEN_LIMIT_RESET;
            mismatches = 0;
            go_idle();
        endfunction

        function void set_register(logic idx, logic [12:0] value);
            if (idx == CFG_ARG_CAP)
                arg_cap = value[CNT_W-1:0];
            else
                len_limit = value[NUM_W-1:0];
        endfunction

        function void clear_number();
            num_value    = 0;
            num_frozen   = 0;
            num_negative = 0;
            cr_seen      = 0;
        endfunction

        function void go_idle();
            clear_number();
            phase      = PH_WAIT_STAR;
            arg_total  = 0;
            cur_arg    = 0;
            bytes_left = 0;
        endfunction

        // Feed one byte of a count or length line; 1 when CR LF closes the line.
        function bit feed_number(logic [7:0] b, logic [PHASE_W-1:0] start_ph,
                                 logic [PHASE_W-1:0] digit_ph);
            int unsigned v;
            if (cr_seen && b == CH_LF)
                return 1'b1;
            cr_seen = (b == CH_CR);
            if (phase == start_ph && b == CH_MINUS) begin
                num_negative = 1;
            end else if (!num_frozen && b >= CH_ZERO && b <= CH_NINE) begin
                v = num_value * 10 + (b - CH_ZERO);
                num_value = (v > NUM_SAT) ? NUM_SAT : v;
            end else begin
                num_frozen = 1;
            end
            phase = digit_ph;
            return 1'b0;
        endfunction

        function void predict_byte(logic [7:0] b);
            parse_beat_t beat;
            int unsigned lim;
            bit          neg;
            beat = '{default: '0};
            case (phase)
                PH_WAIT_STAR: begin
                    if (b == CH_STAR) begin
                        clear_number();
                        phase = PH_COUNT_START;
                    end else begin
                        beat.error_code = ERR_NO_STAR;
                        go_idle();
                    end
                end
                PH_COUNT_START, PH_COUNT_DIGIT: begin
                    if (feed_number(b, PH_COUNT_START, PH_COUNT_DIGIT)) begin
                        lim = (arg_cap < TB_ARG_SLOTS) ? arg_cap : TB_ARG_SLOTS;
                        neg = num_negative && num_value != 0;
                        if (neg || num_value == 0 || num_value > lim) begin
                            beat.error_code = ERR_BAD_COUNT;
                            go_idle();
                        end else begin
                            arg_total      = num_value;
                            cur_arg        = 0;
                            phase          = PH_WAIT_DOLLAR;
                            beat.arg_count = CNT_W'(arg_total);
                        end
                    end
                end
                PH_WAIT_DOLLAR: begin
                    if (b == CH_DOLLAR) begin
                        clear_number();
                        phase = PH_LEN_START;
                    end else begin
                        beat.error_code = ERR_NO_DOLLAR;
                        go_idle();
                    end
                end
                PH_LEN_START, PH_LEN_DIGIT: begin
                    if (feed_number(b, PH_LEN_START, PH_LEN_DIGIT)) begin
                        lim = (len_limit < TB_LENGTH_BOUND) ? len_limit : TB_LENGTH_BOUND;
                        neg = num_negative && num_value != 0;
                        if (neg || num_value >= lim) begin
                            beat.error_code = ERR_BAD_LEN;
                            go_idle();
                        end else begin
                            bytes_left = num_value;
                            phase = (bytes_left != 0) ? PH_DATA : PH_TRAIL_ONE;
                        end
                    end
                end
                PH_DATA: begin
                    beat.data_valid = 1'b1;
                    beat.data_byte  = b;
                    beat.arg_index  = cur_arg[IDX_W-1:0];
                    if (bytes_left > 0)
                        bytes_left--;
                    if (bytes_left == 0)
                        phase = PH_TRAIL_ONE;
                end
                PH_TRAIL_ONE: begin
                    phase = PH_TRAIL_TWO;
                end
                PH_TRAIL_TWO: begin
                    beat.arg_end   = 1'b1;
                    beat.arg_index = cur_arg[IDX_W-1:0];
                    if (cur_arg + 1 >= arg_total) begin
                        beat.command_end = 1'b1;
                        beat.arg_count   = CNT_W'(arg_total);
                        go_idle();
                    end else begin
                        cur_arg++;
                        phase = PH_WAIT_DOLLAR;
                    end
                end
                default: begin
                    go_idle();
                end
            endcase
            if (phase != PH_WAIT_STAR && phase != PH_COUNT_START && phase != PH_COUNT_DIGIT)
                beat.arg_count = CNT_W'(arg_total);
            expected_beats.push_back(beat);
        endfunction

        function void take_byte(logic [7:0] b);
            predict_byte(b);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_beat(logic [23:0] tdata, logic tuser, logic tlast);
            parse_beat_t want;
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected: tdata %h", tdata);
                mismatches++;
                return;
            end
            want = expected_beats.pop_front();
            compare_field("data_valid", want.data_valid, tuser);
            compare_field("data_byte", want.data_byte, tdata[7:0]);
            compare_field("arg_index", want.arg_index, tdata[12:8]);
            compare_field("arg_end", want.arg_end, tdata[13]);
            compare_field("command_end", want.command_end, tlast);
            compare_field("arg_count", want.arg_count, tdata[19:14]);
            compare_field("error_code", want.error_code, tdata[22:20]);
            compare_field("tdata_pad", 8'd0, tdata[23]);
        endfunction

        function int unsigned pending();
            return expected_beats.size();
        endfunction

    endclass

endpackage

@@ sim/resp_command_stream_parser_top_tb.sv @@
// Self-checking testbench for the command stream parser top level.
module resp_command_stream_parser_top_tb;

    import rcsp_pkg::*;
    import rcsp_tb_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 400;
    localparam int END_SETTLE  = 8;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [12:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    command_parse_tracker sb;

    // Bytes waiting to be offered on the input stream.
    logic [7:0] tx_bytes[$];

    // Shadow of the configuration, used only to shape the stimulus.
    int unsigned cfg_arg_cap;
    int unsigned cfg_len_limit;

    bit   src_gaps       = 1'b1;
    logic sink_gaps      = 1'b1;
    logic long_hold_req  = 1'b0;
    bit   long_hold_done = 1'b0;
    int   stall_left     = 0;
    int   cycle_count    = 0;

    resp_command_stream_parser_top #(
        .ARG_SLOTS    (TB_ARG_SLOTS),
        .LENGTH_BOUND (TB_LENGTH_BOUND)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog: fail and end the run once cycle_count reaches CYCLE_LIMIT.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("resp_command_stream_parser_top_tb NOT OK");
            $finish;
        end
    end

    // Result side: check every accepted beat, then pick the next tready.
    // Random stalls come in bursts; one long hold-off is taken on request so
    // the result register fills and the parser pushes back on its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                sb.check_beat(m_tdata, m_tuser, m_tlast);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= (stall_left == 0);
            end else if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD;
                m_tready      <= 1'b0;
            end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 17);
                m_tready  <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Write both registers on back-to-back edges; only call while idle.
    task automatic write_config(int unsigned arg_cap, int unsigned len_limit);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ARG_CAP;
        cfg_wdata <= 13'(arg_cap);
        @(posedge aclk);
        sb.set_register(CFG_ARG_CAP, 13'(arg_cap));
        cfg_index <= CFG_ARG_LEN_LIMIT;
        cfg_wdata <= 13'(len_limit);
        @(posedge aclk);
        sb.set_register(CFG_ARG_LEN_LIMIT, 13'(len_limit));
        cfg_wr_en     <= 1'b0;
        cfg_arg_cap   = arg_cap;
        cfg_len_limit = len_limit;
    endtask

    // Append a number line terminated by CR LF. With decorate set, the line
    // may carry leading zeros, trailing junk after the digits, or a stray CR
    // that is not followed by LF; none of these change the parsed value.
    task automatic push_number(int unsigned value, bit negate, bit decorate);
        string digits;
        int    r;
        digits = $sformatf("%0d", value);
        if (negate)
            tx_bytes.push_back(CH_MINUS);
        if (decorate && $urandom_range(0, 9) == 0) begin
            tx_bytes.push_back(CH_ZERO);
            tx_bytes.push_back(CH_ZERO);
        end
        for (int i = 0; i < digits.len(); i++)
            tx_bytes.push_back(digits[i]);
        r = decorate ? $urandom_range(0, 19) : 19;
        if (r == 0) begin
            tx_bytes.push_back(8'h20);
            tx_bytes.push_back(CH_ZERO + 8'd7);
        end else if (r == 1) begin
            tx_bytes.push_back(CH_CR);
            tx_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        tx_bytes.push_back(CH_CR);
        tx_bytes.push_back(CH_LF);
    endtask

    // One bulk string: length line, payload, two unchecked trailing bytes.
    task automatic push_arg(int unsigned len);
        tx_bytes.push_back(CH_DOLLAR);
        push_number(len, len == 0 && $urandom_range(0, 3) == 0, 1'b1);
        repeat (len) tx_bytes.push_back(8'($urandom_range(0, 255)));
        tx_bytes.push_back(8'($urandom_range(0, 255)));
        tx_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Build one random command. Most are well formed with random content;
    // the rest are line noise, bad counts, a missing '$' or a bad length.
    task automatic gen_command();
        int unsigned cnt_lim, len_lim, len_max, n, len;
        int          r, r2, bad_at;
        logic [7:0]  junk;
        cnt_lim = (cfg_arg_cap < TB_ARG_SLOTS) ? cfg_arg_cap : TB_ARG_SLOTS;
        len_lim = (cfg_len_limit < TB_LENGTH_BOUND) ? cfg_len_limit : TB_LENGTH_BOUND;
        len_max = len_lim - 1;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (r < 16) begin
            tx_bytes.push_back(CH_STAR);
            case ($urandom_range(0, 3))
                0: push_number(0, $urandom_range(0, 1), 1'b1);
                1: push_number($urandom_range(1, 40), 1'b1, 1'b1);
                2: push_number(cnt_lim + $urandom_range(1, 20), 1'b0, 1'b1);
                default: push_number($urandom_range(8192, 99999), 1'b0, 1'b0);
            endcase
        end else begin
            if ($urandom_range(0, 9) < 7)
                n = $urandom_range(1, (cnt_lim < 3) ? cnt_lim : 3);
            else
                n = $urandom_range(1, cnt_lim);
            tx_bytes.push_back(CH_STAR);
            push_number(n, 1'b0, 1'b1);
            bad_at = (r >= 84) ? $urandom_range(0, n - 1) : n;
            for (int k = 0; k < n; k++) begin
                if (k == bad_at) begin
                    if (r < 92) begin
                        junk = 8'($urandom_range(0, 255));
                        if (junk == CH_DOLLAR)
                            junk = junk + 8'd1;
                        tx_bytes.push_back(junk);
                    end else begin
                        tx_bytes.push_back(CH_DOLLAR);
                        case ($urandom_range(0, 2))
                            0: push_number($urandom_range(1, 20), 1'b1, 1'b1);
                            1: push_number(len_lim + $urandom_range(0, 50), 1'b0, 1'b1);
                            default: push_number($urandom_range(10000, 99999), 1'b0, 1'b0);
                        endcase
                    end
                    break;
                end
                r2 = $urandom_range(0, 99);
                if (len_max == 0 || r2 < 10)
                    len = 0;
                else if (r2 < 98)
                    len = $urandom_range(1, (len_max < 8) ? len_max : 8);
                else
                    len = $urandom_range(1, (len_max < 300) ? len_max : 300);
                push_arg(len);
            end
        end
    endtask

    // Offer every queued byte; note each one on the edge it is accepted.
    task automatic send_bytes();
        logic [7:0] b;
        while (tx_bytes.size() != 0) begin
            b = tx_bytes.pop_front();
            if (src_gaps && $urandom_range(0, 7) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= b;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            sb.take_byte(b);
        end
        s_tvalid <= 1'b0;
    endtask

    // Hold the sender until every predicted beat has come back.
    task automatic wait_drain();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic run_phase(int unsigned arg_cap, int unsigned len_limit,
                             int unsigned target, bit hold_sink);
        write_config(arg_cap, len_limit);
        while (tx_bytes.size() < target) gen_command();
        if (hold_sink)
            long_hold_req <= 1'b1;
        send_bytes();
        wait_drain();
    endtask

    initial begin
        sb = new();
        cfg_arg_cap   = ARG_CAP_RESET;
        cfg_len_limit = LEN_LIMIT_RESET;

        // Hold reset low, then release it once for the whole run.
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the tightest settings: one argument, length 0 only.
        write_config(1, 1);
        // missing star
        tx_bytes.push_back(8'hFF);
        // count above the argument cap
        tx_bytes.push_back(CH_STAR);
        push_number(2, 1'b0, 1'b0);
        // length at the limit
        tx_bytes.push_back(CH_STAR);
        push_number(1, 1'b0, 1'b0);
        tx_bytes.push_back(CH_DOLLAR);
        push_number(1, 1'b0, 1'b0);
        // zero length written as "-0", last argument closes the command
        tx_bytes.push_back(CH_STAR);
        push_number(1, 1'b0, 1'b0);
        tx_bytes.push_back(CH_DOLLAR);
        push_number(0, 1'b1, 1'b0);
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'hFF);
        // missing dollar
        tx_bytes.push_back(CH_STAR);
        push_number(1, 1'b0, 1'b0);
        tx_bytes.push_back(8'hFF);
        send_bytes();
        wait_drain();

        // Random part over several settings, widest and narrowest included.
        run_phase(32, 4096, 220, 1'b0);
        run_phase(1, 1, 150, 1'b0);
        run_phase(7, 512, 220, 1'b1);
        run_phase($urandom_range(1, 32), $urandom_range(1, 64), 220, 1'b0);
        run_phase(32, 16, 200, 1'b0);

        // Last stretch runs flat out on both sides.
        src_gaps  = 1'b0;
        sink_gaps <= 1'b0;
        run_phase($urandom_range(1, 32), $urandom_range(1, 4096), 220, 1'b0);

        // Let any stray beat show up before calling the result.
        repeat (END_SETTLE) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("resp_command_stream_parser_top_tb OK");
        else
            $display("resp_command_stream_parser_top_tb NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
design/rcsp_pkg.sv
design/resp_command_stream_parser_top.sv
sim/rcsp_tb_pkg.sv
sim/resp_command_stream_parser_top_tb.sv
